// ===== rtl/gfs_pkg.sv =====
`timescale 1ns / 1ps
package gfs_pkg;
	localparam int ITERATIONS_DEFAULT = 5;
	localparam logic [31:0] ONE_HALF_Q31 = 32'hC000_0000;
	localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
	localparam logic [31:0] HALF_Q31 = 32'h4000_0000;
	localparam logic [7:0] EXP_BIAS_HI = 8'd64;
	localparam logic [7:0] EXP_BIAS_LO = 8'd63;
endpackage

// ===== rtl/goldschmidt_float_sqrt.sv =====
`timescale 1ns / 1ps
// Channel   | Ports                  | Transfer
// ----------+------------------------+----------------------------------
// operand   | start, operand_bits    | start high while busy is low
// result    | done, root_bits        | done high for one cycle
//
// The pipeline accepts one transaction per cycle; busy is always low.
// An input register, three stages per iteration (correction term, the two
// products, the final X product) and one normalization register lie between
// operand and result. Reset clears only the valid bits.
// The receiver cannot stall, so results leave on the cycle they are ready.
module goldschmidt_float_sqrt import gfs_pkg::*; #(
	parameter int ITERATIONS = ITERATIONS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] operand_bits,
	output logic        done,
	output logic [31:0] root_bits
);
	logic              v_s0;
	logic [31:0]       x_s0, tag_s0;
	logic [ITERATIONS:0]       v_c;
	logic [31:0]       x_c [ITERATIONS+1];
	logic [31:0]       z_c [ITERATIONS+1];
	logic [31:0]       t_c [ITERATIONS+1];
	logic [63:0]       p_c [ITERATIONS+1];
	logic              done_q;
	logic [31:0]       root_q;
	logic [7:0]        ehalf;
	logic [31:0]       res;

	assign busy = 1'b0;

	// Seed: odd exponent keeps 1.m, even exponent halves it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else begin
			v_s0 <= start;
		end
	end

	always_ff @(posedge clk) begin
		tag_s0 <= operand_bits;
		if (operand_bits[23]) begin
			x_s0 <= ONE_Q31 + {1'b0, operand_bits[22:0], 8'd0};
		end else begin
			x_s0 <= HALF_Q31 + {2'b0, operand_bits[22:0], 7'd0};
		end
	end

	assign v_c[0] = v_s0;
	assign x_c[0] = x_s0;
	assign z_c[0] = x_s0;
	assign t_c[0] = tag_s0;
	assign p_c[0] = 64'(x_s0) << 31;

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
		gfs_step u_step (
			.clk(clk), .arst_n(arst_n),
			.in_valid(v_c[i]), .x_in(x_c[i]), .z_in(z_c[i]), .tag_in(t_c[i]),
			.out_valid(v_c[i+1]), .x_out(x_c[i+1]), .z_out(z_c[i+1]),
			.p_out(p_c[i+1]), .tag_out(t_c[i+1])
		);
	end

	// Normalize on bit 62 of the last Z*D product; the mantissa is truncated.
	always_comb begin
		ehalf = {1'b0, t_c[ITERATIONS][30:24]};
		if (p_c[ITERATIONS][62]) begin
			res = {1'b0, (EXP_BIAS_HI + ehalf), 23'd0} + {9'd0, p_c[ITERATIONS][61:39]};
		end else begin
			res = {1'b0, (EXP_BIAS_LO + ehalf), 23'd0} + {9'd0, p_c[ITERATIONS][60:38]};
		end
		res[31] = res[31] | t_c[ITERATIONS][31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_c[ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		root_q <= res;
	end

	assign done = done_q;
	assign root_bits = root_q;
endmodule

// ===== rtl/gfs_step.sv =====
`timescale 1ns / 1ps
// One Goldschmidt iteration over three register stages.
module gfs_step import gfs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [31:0] x_in,
	input  logic [31:0] z_in,
	input  logic [31:0] tag_in,
	output logic        out_valid,
	output logic [31:0] x_out,
	output logic [31:0] z_out,
	output logic [63:0] p_out,
	output logic [31:0] tag_out
);
	logic        v_s1, v_s2, v_s3;
	logic [31:0] x_s1, z_s1, d_s1, tag_s1;
	logic [63:0] dd_s2, zd_s2;
	logic [31:0] x_s2, tag_s2;
	logic [63:0] xd_s3, zd_s3;
	logic [31:0] tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		d_s1   <= ONE_HALF_Q31 - {1'b0, x_in[31:1]};
		x_s1   <= x_in;
		z_s1   <= z_in;
		tag_s1 <= tag_in;
		dd_s2  <= 64'(d_s1) * 64'(d_s1);
		zd_s2  <= 64'(z_s1) * 64'(d_s1);
		x_s2   <= x_s1;
		tag_s2 <= tag_s1;
		xd_s3  <= 64'(x_s2) * 64'(dd_s2[62:31]);
		zd_s3  <= zd_s2;
		tag_s3 <= tag_s2;
	end

	assign out_valid = v_s3;
	assign x_out = xd_s3[62:31];
	assign z_out = zd_s3[62:31];
	assign p_out = zd_s3;
	assign tag_out = tag_s3;
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for goldschmidt_float_sqrt. Operands are driven on the falling
// clock edge and results are sampled on the rising edge. A scoreboard class
// computes the expected root of each accepted operand with its own
// Goldschmidt model and checks every result against the oldest one waiting.
module tb_top;
	import gfs_pkg::*;

	localparam int NUM_ITER = ITERATIONS_DEFAULT;
	localparam int LATENCY = 3 * NUM_ITER + 2;
	localparam int RANDOM_COUNT = 1800;

	// The scoreboard holds the expected roots in the order the operands
	// were accepted. The pipeline keeps that order.
	class sqrt_scoreboard;
		logic [31:0] pending_roots[$];
		int mismatches;
		int checked;

		function new();
			mismatches = 0;
			checked = 0;
		endfunction

		// This computes the square root bit for bit as the block does.
		// Every Q62 product is cut back to Q31 by keeping bits 62..31.
		function logic [31:0] predict_root(logic [31:0] operand);
			logic [31:0] x;
			logic [31:0] z;
			logic [31:0] d;
			logic [31:0] dd;
			logic [63:0] zd;
			logic [63:0] prod;
			logic [6:0] ehalf;
			logic [31:0] root;
			ehalf = operand[30:24];
			// Odd exponents start at 1.m and even ones start at 0.5 * 1.m.
			if (operand[23]) begin
				x = ONE_Q31 + {1'b0, operand[22:0], 8'd0};
			end else begin
				x = HALF_Q31 + {2'b0, operand[22:0], 7'd0};
			end
			z = x;
			zd = {1'b0, z, 31'd0};
			for (int i = 0; i < NUM_ITER; i++) begin
				d = ONE_HALF_Q31 - (x >> 1);
				prod = 64'(d) * 64'(d);
				dd = prod[62:31];
				zd = 64'(z) * 64'(d);
				prod = 64'(x) * 64'(dd);
				x = prod[62:31];
				z = zd[62:31];
			end
			// The last Z*D product is normalized on its bit 62.
			if (zd[62]) begin
				root = ({25'd0, ehalf} + 32'd64) << 23;
				root = root + {9'd0, zd[61:39]};
			end else begin
				root = ({25'd0, ehalf} + 32'd63) << 23;
				root = root + {9'd0, zd[60:38]};
			end
			root[31] = root[31] | operand[31];
			return root;
		endfunction

		function void note_operand(logic [31:0] operand);
			pending_roots.push_back(predict_root(operand));
		endfunction

		function void check_root(logic [31:0] actual);
			logic [31:0] expected;
			if (pending_roots.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: root %h arrived with nothing expected", actual);
				end
				return;
			end
			expected = pending_roots.pop_front();
			checked++;
			if (actual !== expected) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: root_bits expected %h got %h", expected, actual);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [31:0] operand_bits;
	logic done;
	logic [31:0] root_bits;

	sqrt_scoreboard sb;
	int directed_count;
	int random_count;
	int pauses_full;

	goldschmidt_float_sqrt dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operand_bits(operand_bits),
		.done(done),
		.root_bits(root_bits)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Every result is checked at the rising edge that ends its strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_root(root_bits);
		end
	end

	// This drives one operand and holds it until a transaction happens.
	// Start stays high into the next call, so back-to-back operands never
	// drop the strobe within one time step.
	task automatic send_operand(logic [31:0] value);
		start <= 1'b1;
		operand_bits <= value;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		sb.note_operand(value);
		@(negedge clk);
	endtask

	// Most gaps are zero or short; a few are long.
	task automatic idle_gap();
		int len;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			len = 0;
		end else if (pick < 92) begin
			len = $urandom_range(1, 3);
		end else begin
			len = $urandom_range(8, 40);
		end
		if (len > 0) begin
			start <= 1'b0;
			operand_bits <= $urandom();
			repeat (len) @(negedge clk);
		end
	endtask

	// The sender holds off until the pipeline has drained completely.
	task automatic drain_pipeline();
		start <= 1'b0;
		while (sb.pending_roots.size() != 0) begin
			@(negedge clk);
		end
		pauses_full++;
	endtask

	// Random operands: mostly normal numbers of either sign, with some raw
	// patterns, zeros, denormals, infinities and NaNs mixed in.
	function automatic logic [31:0] random_operand();
		logic [31:0] value;
		int pick;
		pick = $urandom_range(0, 99);
		value = $urandom();
		if (pick < 10) begin
			value[30:23] = 8'd0;
		end else if (pick < 18) begin
			value[30:23] = 8'hFF;
		end else if (pick < 24) begin
			value[22:0] = $urandom_range(0, 1) ? 23'd0 : 23'h7FFFFF;
		end
		return value;
	endfunction

	initial begin
		logic [31:0] directed[$];
		sb = new();
		pauses_full = 0;
		directed_count = 0;
		random_count = 0;
		start = 1'b0;
		operand_bits = 32'd0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: both zeros, denormals, one and other powers, odd and
		// even exponents at mantissa extremes, infinities, NaNs, negatives.
		directed = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h007F_FFFF,
			32'h0080_0000, 32'h3F80_0000, 32'h4000_0000, 32'h4080_0000,
			32'h3F7F_FFFF, 32'h3FFF_FFFF, 32'h4000_0001, 32'h407F_FFFF,
			32'h7F7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hBF80_0000, 32'hC0490FDB,
			32'h3E80_0000, 32'h5555_5555, 32'hAAAA_AAAA};
		foreach (directed[i]) begin
			send_operand(directed[i]);
			directed_count++;
		end
		drain_pipeline();

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			idle_gap();
			send_operand(random_operand());
			random_count++;
			if (i == RANDOM_COUNT / 2) begin
				drain_pipeline();
			end
		end
		start <= 1'b0;

		while (sb.pending_roots.size() != 0) begin
			@(negedge clk);
		end
		repeat (LATENCY + 5) @(negedge clk);

		$display("Covered %0d directed and %0d random operands, %0d results checked,",
			directed_count, random_count, sb.checked);
		$display("with %0d full drains and %0d mismatches.", pauses_full, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_roots.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Safety limit far beyond the slowest correct run.
	initial begin
		#(12 * 400000);
		$display("ERROR: timeout");
		$display("status: fail");
		$finish;
	end
endmodule
